### rtl/core/u2ds_pkg.sv
package u2ds_pkg;

  // ascii codes and radix limits
  localparam logic [6:0] CHAR_ZERO     = 7'd48;
  localparam logic [6:0] CHAR_UPPER_A  = 7'd65;
  localparam logic [5:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;

  // quotient bits resolved per division cycle
  localparam int STEP_BITS = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_OUT
  } u2ds_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd_en;
    logic rd_dec;
  } u2ds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic rd_first;
  } u2ds_sts_t;

endpackage

### rtl/core/u2ds_ram.sv
module u2ds_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/u2ds_ctrl.sv
module u2ds_ctrl
  import u2ds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  u2ds_sts_t sts_i,
  output u2ds_cmd_t cmd_o
);

  u2ds_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = sts_i.quot_zero ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.rd_first) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_dec = 1'b1;
            state_d      = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/u2ds_dpath.sv
module u2ds_dpath
  import u2ds_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [5:0]            radix_i,
  input  u2ds_cmd_t             cmd_i,
  output u2ds_sts_t             sts_o,
  output logic [6:0]            char_code_o,
  output logic [5:0]            digit_total_o,
  output logic                  last_o
);

  localparam int DIV_W  = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NCHUNK = DIV_W / STEP_BITS;
  localparam int CHW    = $clog2(NCHUNK + 1);
  localparam int CW     = $clog2(VALUE_BITS + 1);
  localparam int AW     = $clog2(VALUE_BITS);

  logic [DIV_W-1:0] quot_q, quot_d;
  logic [5:0]       rem_q, rem_d;
  logic [5:0]       radix_q, radix_d;
  logic [CHW-1:0]   chunk_q, chunk_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;

  logic [5:0]           step_rem;
  logic [STEP_BITS-1:0] step_qb;
  logic [5:0]           rd_digit;
  logic [CW+5:0]        cnt_ext;

  // restoring division, STEP_BITS quotient bits per cycle
  always_comb begin
    logic [6:0] t;
    logic [5:0] r;
    r       = rem_q;
    step_qb = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, quot_q[DIV_W-1-i]};
      if (t >= {1'b0, radix_q}) begin
        t                         = t - {1'b0, radix_q};
        step_qb[STEP_BITS-1-i]    = 1'b1;
      end
      r = t[5:0];
    end
    step_rem = r;
  end

  always_comb begin
    quot_d   = quot_q;
    rem_d    = rem_q;
    radix_d  = radix_q;
    chunk_d  = chunk_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load) begin
      quot_d  = DIV_W'(value_i);
      rem_d   = '0;
      chunk_d = '0;
      cnt_d   = '0;
      if (radix_i < RADIX_MIN) begin
        radix_d = RADIX_MIN;
      end else if (radix_i > RADIX_MAX) begin
        radix_d = RADIX_MAX;
      end else begin
        radix_d = radix_i;
      end
    end
    if (cmd_i.div_step) begin
      quot_d  = (quot_q << STEP_BITS) | DIV_W'(step_qb);
      rem_d   = step_rem;
      chunk_d = chunk_q + CHW'(1);
    end
    if (cmd_i.store) begin
      rem_d    = '0;
      chunk_d  = '0;
      cnt_d    = cnt_q + CW'(1);
      rd_idx_d = cnt_q[AW-1:0];
    end
    if (cmd_i.rd_dec) begin
      rd_idx_d = rd_idx_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q  <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      chunk_q  <= chunk_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

  // digits land least significant first, read back in reverse
  u2ds_ram #(
    .WIDTH (6),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.store),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (rem_q),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_digit)
  );

  assign sts_o.div_done  = (chunk_q == CHW'(NCHUNK - 1));
  assign sts_o.quot_zero = (quot_q == '0);
  assign sts_o.rd_first  = (rd_idx_q == '0);

  always_comb begin
    if (rd_digit < DECIMAL_LIMIT) begin
      char_code_o = CHAR_ZERO + {1'b0, rd_digit};
    end else begin
      char_code_o = CHAR_UPPER_A + {1'b0, rd_digit - DECIMAL_LIMIT};
    end
  end

  assign cnt_ext       = {6'd0, cnt_q};
  assign digit_total_o = cnt_ext[5:0];
  assign last_o        = (rd_idx_q == '0);

endmodule

### rtl/core/unsigned_to_digit_string.sv
// unsigned binary value to ascii digit string in radix 2..36
// input channel: value_i / radix_i with in_valid_i, in_stall_o. one beat is one
//   number; radix below 2 is taken as 2, above 36 as 36.
// output channel: one beat per digit, most significant first, with char_code_o,
//   digit_total_o (same on every beat of a number) and last_o on the final digit.
// zero gives the single digit '0'.
// one number at a time: in_stall_o stays high from acceptance until the last
//   digit beat is taken.
// sequence: per digit, division steps until every quotient chunk is done, then a
//   store step, all in the shared 8-bit-per-cycle restoring divider; then each
//   output beat is a digit ram read, then present.
// a stalled output beat holds its payload until taken; the divider does not
//   advance while the output stalls.
// reset (async, active low) returns the controller to idle; the digit ram is
//   not cleared and needs no clearing pass.
module unsigned_to_digit_string
  import u2ds_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [5:0]            radix_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [6:0]            char_code_o,
  output logic [5:0]            digit_total_o,
  output logic                  last_o
);

  u2ds_cmd_t cmd;
  u2ds_sts_t sts;

  u2ds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u2ds_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .radix_i       (radix_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .char_code_o   (char_code_o),
    .digit_total_o (digit_total_o),
    .last_o        (last_o)
  );

  // no new number while digits are still going out
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during digit output");

  // the last digit taken ends the string
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> (!out_valid_o && !in_stall_o))
    else $error("output continues after last digit");

  // a non-final digit taken is followed by another digit of the same string
  a_more_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> (!out_valid_o ##1 out_valid_o))
    else $error("string ended without last flag");

  // the string always has at least one digit
  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_total_o != 6'd0))
    else $error("zero digit total");

endmodule
